// ----- src/b2i_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2i_pkg
// Shared types and constants of the BGRA to I420 converter.
// ----------------------------------------------------------------------------
package b2i_pkg;

	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int DIM_W      = CFG_W + 1;
	localparam int LUMA_W     = 24;
	localparam int CHROMA_W   = 22;
	localparam int SUM_W      = 18;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	localparam logic [1:0] PLANE_Y = 2'd0;
	localparam logic [1:0] PLANE_U = 2'd1;
	localparam logic [1:0] PLANE_V = 2'd2;

	// BT.601 integer weights.
	localparam logic signed [SUM_W-1:0] K_YR = 18'sd66;
	localparam logic signed [SUM_W-1:0] K_YG = 18'sd129;
	localparam logic signed [SUM_W-1:0] K_YB = 18'sd25;
	localparam logic signed [SUM_W-1:0] K_UR = -18'sd38;
	localparam logic signed [SUM_W-1:0] K_UG = -18'sd74;
	localparam logic signed [SUM_W-1:0] K_UB = 18'sd112;
	localparam logic signed [SUM_W-1:0] K_VR = 18'sd112;
	localparam logic signed [SUM_W-1:0] K_VG = -18'sd94;
	localparam logic signed [SUM_W-1:0] K_VB = -18'sd18;
	localparam logic [7:0] Y_BIAS = 8'd16;
	localparam logic [7:0] C_BIAS = 8'd128;

	typedef struct packed {
		logic [7:0]          blue;
		logic [7:0]          green;
		logic [7:0]          red;
		logic [LUMA_W-1:0]   luma_pos;
		logic [CHROMA_W-1:0] chroma_pos;
		logic                has_chroma;
		logic                frame_end;
	} pixel_job_t;

	typedef struct packed {
		logic       valid;
		pixel_job_t job;
	} queue_head_t;

	typedef enum logic [1:0] {
		PH_EMPTY,
		PH_Y,
		PH_U,
		PH_V
	} phase_t;

endpackage
`default_nettype wire

// ----- src/b2i_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2i_front
// Holds the frame geometry and raster counters and tags each pixel beat.
// ----------------------------------------------------------------------------
module b2i_front import b2i_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 pixel_valid,
	output      logic                 pixel_ready,
	input  wire logic [7:0]           blue,
	input  wire logic [7:0]           green,
	input  wire logic [7:0]           red,
	input  wire logic                 push_ready,
	output      logic                 push,
	output      pixel_job_t           push_job
);

	localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);

	logic [CFG_W-1:0]    frame_width_q;
	logic [CFG_W-1:0]    frame_height_q;
	logic [COL_W-1:0]    column_q;
	logic [ROW_W-1:0]    row_q;
	logic [LUMA_W-1:0]   luma_pos_q;
	logic [CHROMA_W-1:0] chroma_pos_q;

	logic [DIM_W-1:0] eff_width;
	logic [DIM_W-1:0] eff_height;
	logic             row_end;
	logic             frame_end;
	logic             has_chroma;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_width  = ({1'b0, frame_width_q} < MAX_W_D) ? {1'b0, frame_width_q} : MAX_W_D;
		eff_height = ({1'b0, frame_height_q} < MAX_H_D) ? {1'b0, frame_height_q} : MAX_H_D;
		// A zero register behaves like one: the compare is on count plus one.
		row_end    = (DIM_W'(column_q) + DIM_W'(1)) >= eff_width;
		frame_end  = row_end && ((DIM_W'(row_q) + DIM_W'(1)) >= eff_height);
		has_chroma = !row_q[0] && !column_q[0];
	end

	assign pixel_ready = push_ready;
	assign push        = pixel_valid && push_ready;

	always_comb begin
		push_job.blue       = blue;
		push_job.green      = green;
		push_job.red        = red;
		push_job.luma_pos   = luma_pos_q;
		push_job.chroma_pos = chroma_pos_q;
		push_job.has_chroma = has_chroma;
		push_job.frame_end  = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			row_q        <= '0;
			luma_pos_q   <= '0;
			chroma_pos_q <= '0;
		end else if (push) begin
			if (frame_end) begin
				column_q     <= '0;
				row_q        <= '0;
				luma_pos_q   <= '0;
				chroma_pos_q <= '0;
			end else begin
				luma_pos_q <= luma_pos_q + LUMA_W'(1);
				if (has_chroma) begin
					chroma_pos_q <= chroma_pos_q + CHROMA_W'(1);
				end
				if (row_end) begin
					column_q <= '0;
					row_q    <= row_q + ROW_W'(1);
				end else begin
					column_q <= column_q + COL_W'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/b2i_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2i_fifo
// Short queue of tagged pixels between the front and the back.
// ----------------------------------------------------------------------------
module b2i_fifo import b2i_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire pixel_job_t  push_job,
	output      logic        push_ready,
	input  wire logic        pop,
	output      queue_head_t head
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	pixel_job_t       slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign push_ready = count_q != (PTR_W+1)'(DEPTH);
	assign head.valid = count_q != '0;
	assign head.job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/b2i_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2i_back
// Converts one queued pixel to Y, U and V and emits its samples in order.
// ----------------------------------------------------------------------------
module b2i_back import b2i_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire queue_head_t head,
	output      logic        pop,
	output      logic        result_valid,
	input  wire logic        result_ready,
	output      logic [1:0]  plane,
	output      logic [23:0] plane_offset,
	output      logic [7:0]  sample,
	output      logic        last_of_pixel,
	output      logic        last_of_frame
);

	phase_t              phase_q;
	phase_t              phase_d;
	logic [7:0]          y_q;
	logic [7:0]          u_q;
	logic [7:0]          v_q;
	logic [LUMA_W-1:0]   luma_pos_q;
	logic [CHROMA_W-1:0] chroma_pos_q;
	logic                has_chroma_q;
	logic                frame_end_q;

	logic signed [SUM_W-1:0] r_s;
	logic signed [SUM_W-1:0] g_s;
	logic signed [SUM_W-1:0] b_s;
	logic signed [SUM_W-1:0] y_sum;
	logic signed [SUM_W-1:0] u_sum;
	logic signed [SUM_W-1:0] v_sum;

	logic        out_free;
	logic        emit;
	logic        last;
	logic        load;
	logic [1:0]  plane_d;
	logic [23:0] offset_d;
	logic [7:0]  sample_d;

	// Bits 15:8 of the sum are the floor shift by eight, kept to a byte.
	always_comb begin
		r_s   = $signed({10'd0, head.job.red});
		g_s   = $signed({10'd0, head.job.green});
		b_s   = $signed({10'd0, head.job.blue});
		y_sum = K_YR * r_s + K_YG * g_s + K_YB * b_s;
		u_sum = K_UR * r_s + K_UG * g_s + K_UB * b_s;
		v_sum = K_VR * r_s + K_VG * g_s + K_VB * b_s;
	end

	always_comb begin
		out_free = !result_valid || result_ready;
		emit     = 1'b0;
		last     = 1'b0;
		plane_d  = PLANE_Y;
		offset_d = luma_pos_q;
		sample_d = y_q;
		unique case (phase_q)
			PH_EMPTY: begin
				emit = 1'b0;
			end
			PH_Y: begin
				emit = out_free;
				last = !has_chroma_q;
			end
			PH_U: begin
				emit     = out_free;
				plane_d  = PLANE_U;
				offset_d = {2'b00, chroma_pos_q};
				sample_d = u_q;
			end
			PH_V: begin
				emit     = out_free;
				last     = 1'b1;
				plane_d  = PLANE_V;
				offset_d = {2'b00, chroma_pos_q};
				sample_d = v_q;
			end
			default: ;
		endcase
		load = head.valid && ((phase_q == PH_EMPTY) || (emit && last));
		pop  = load;

		phase_d = phase_q;
		if (load) begin
			phase_d = PH_Y;
		end else if (emit && last) begin
			phase_d = PH_EMPTY;
		end else if (emit) begin
			phase_d = (phase_q == PH_Y) ? PH_U : PH_V;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_EMPTY;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			y_q          <= y_sum[15:8] + Y_BIAS;
			u_q          <= u_sum[15:8] + C_BIAS;
			v_q          <= v_sum[15:8] + C_BIAS;
			luma_pos_q   <= head.job.luma_pos;
			chroma_pos_q <= head.job.chroma_pos;
			has_chroma_q <= head.job.has_chroma;
			frame_end_q  <= head.job.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			plane         <= plane_d;
			plane_offset  <= offset_d;
			sample        <= sample_d;
			last_of_pixel <= last;
			last_of_frame <= last && frame_end_q;
		end
	end

endmodule
`default_nettype wire

// ----- src/bgra_to_i420_converter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgra_to_i420_converter_core
// BT.601 pixel to planar I420 converter, one sample per result beat.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  pixel    | pixel_valid / pixel_ready   | blue, green, red
//  result   | result_valid / result_ready | plane, plane_offset, sample,
//           |                             | last_of_pixel, last_of_frame
//  config   | cfg_write_en                | cfg_index, cfg_data
//
// The result port gives one beat per cycle while pixels are queued and
// result_ready is high. A pixel on an even row and even column gives three
// beats (Y, U, V), any other pixel one, so a 2x2 block gives six beats.
// Pixels enter a four-entry queue at one per cycle while it has room. Reset
// sets the geometry to 640 by 480 and starts at the top-left pixel.
// ----------------------------------------------------------------------------
module bgra_to_i420_converter_core import b2i_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 pixel_valid,
	output      logic                 pixel_ready,
	input  wire logic [7:0]           blue,
	input  wire logic [7:0]           green,
	input  wire logic [7:0]           red,
	output      logic                 result_valid,
	input  wire logic                 result_ready,
	output      logic [1:0]           plane,
	output      logic [23:0]          plane_offset,
	output      logic [7:0]           sample,
	output      logic                 last_of_pixel,
	output      logic                 last_of_frame
);

	logic        push;
	logic        push_ready;
	pixel_job_t  push_job;
	logic        pop;
	queue_head_t head;

	b2i_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.push_ready   (push_ready),
		.push         (push),
		.push_job     (push_job)
	);

	b2i_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.head       (head)
	);

	b2i_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.plane         (plane),
		.plane_offset  (plane_offset),
		.sample        (sample),
		.last_of_pixel (last_of_pixel),
		.last_of_frame (last_of_frame)
	);

endmodule
`default_nettype wire
